// ----- rtl/cmw_pkg.sv -----
// ----------------------------------------------------------------------------
// Column melt wipe package
// Types, command and register codes, constants and small helpers shared by
// the column melt wipe block and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package cmw_pkg;

  localparam int FIELD_W = 13;
  localparam int CFG_INDEX_W = 2;

  localparam logic [1:0] ACT_SEED = 2'd0;
  localparam logic [1:0] ACT_ADVANCE = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [FIELD_W-1:0] SCREEN_WIDTH_RESET = 13'd320;
  localparam logic [FIELD_W-1:0] SCREEN_HEIGHT_RESET = 13'd200;

  localparam int SEED_MASK = 15;
  localparam int SEED_SPAN = 15;
  localparam int GROW_LIMIT = 16;
  localparam int GROW_STEP = 8;

  localparam logic [1:0] PHASE_LEFT = 2'd0;
  localparam logic [1:0] PHASE_RIGHT = 2'd1;
  localparam logic [1:0] PHASE_TOP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_ADV,
    ST_ADV_TAIL,
    ST_Q_LOAD,
    ST_Q_MUL,
    ST_Q_DIV
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] random_value;
    logic [5:0] tick_count;
    logic [8:0] column;
  } in_item_t;

  typedef struct packed {
    logic               done_res;
    logic [FIELD_W-1:0] left_x;
    logic [FIELD_W-1:0] right_x;
    logic [FIELD_W-1:0] strip_top;
    logic               visible;
  } out_item_t;

  // Residue modulo three of a byte: base-four digits are summed twice.
  function automatic logic [1:0] mod3(input logic [7:0] value);
    logic [3:0] digit_sum;
    logic [2:0] fold_sum;
    logic [1:0] residue;
    digit_sum = 4'(value[1:0]) + 4'(value[3:2]) + 4'(value[5:4]) + 4'(value[7:6]);
    fold_sum = 3'(digit_sum[1:0]) + 3'(digit_sum[3:2]);
    case (fold_sum)
      3'd1, 3'd4: residue = 2'd1;
      3'd2, 3'd5: residue = 2'd2;
      default: residue = 2'd0;
    endcase
    return residue;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/column_melt_wipe.sv -----
// ----------------------------------------------------------------------------
// Column melt wipe
// Keeps one drop offset per screen column, seeds them from random bytes,
// runs melt ticks over all columns and reports the strip of one column.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high while busy is low; busy stays
// high until its result has been issued. Every transaction gives exactly one
// result, shown for one cycle with result_valid high; the receiver cannot
// stall, so nothing waits on the output side.
// A seed of column zero is written from idle; others read the left neighbour.
// An advance streams every offset through the read-modify-write path of the
// offset RAM once per tick, one column per cycle, with a tail state after
// the last column. An advance of zero ticks gives its result from idle.
// A query of a column in range uses the one shared multiplier twice for
// each strip edge and the strip top: first for the scaled product, then
// for a multiplication by the reciprocal of the column count or melt height.
// Configuration writes take effect at once; the user must make them only
// while idle, as the block does not enforce it. Reset clears the seed
// position and restores the screen size; offsets are undefined until seeded.
// ----------------------------------------------------------------------------
`default_nettype none

module column_melt_wipe #(
  parameter int NUM_COLUMNS = 320,
  parameter int MELT_HEIGHT = 200
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire cmw_pkg::in_item_t                   command,
  output logic                                     result_valid,
  output cmw_pkg::out_item_t                       result,
  input  wire logic                                cfg_we,
  input  wire logic [cmw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [cmw_pkg::FIELD_W-1:0]         cfg_data
);

  localparam int MAG_W = $clog2(MELT_HEIGHT + 1);
  localparam int OFF_W = MAG_W + 1;
  localparam int ADDR_W = $clog2(NUM_COLUMNS);
  localparam int MUL_A_W = (MAG_W > 10) ? MAG_W : 10;
  localparam int PROD_W = MUL_A_W + cmw_pkg::FIELD_W;
  localparam int RECIP_W = PROD_W + 2;
  localparam int MUL_W = 2 * RECIP_W;
  localparam int SHIFT_COL = PROD_W + $clog2(NUM_COLUMNS);
  localparam int SHIFT_MELT = PROD_W + $clog2(MELT_HEIGHT);

  localparam logic signed [OFF_W:0] MELT_X = (OFF_W + 1)'(MELT_HEIGHT);
  localparam logic signed [OFF_W:0] GROW_LIMIT_X = (OFF_W + 1)'(cmw_pkg::GROW_LIMIT);
  localparam logic signed [OFF_W:0] GROW_STEP_X = (OFF_W + 1)'(cmw_pkg::GROW_STEP);
  localparam logic signed [OFF_W:0] SEED_MIN_X = -((OFF_W + 1)'(cmw_pkg::SEED_SPAN));
  localparam logic signed [OFF_W:0] ONE_X = (OFF_W + 1)'(1);
  localparam logic signed [OFF_W:0] ZERO_X = '0;
  localparam logic [ADDR_W-1:0] LAST_COL = ADDR_W'(NUM_COLUMNS - 1);
  localparam logic [10:0] COL_LIMIT = 11'(NUM_COLUMNS);
  localparam logic [RECIP_W-1:0] RECIP_COL = RECIP_W'(
    ((64'd1 << SHIFT_COL) + 64'(NUM_COLUMNS) - 64'd1) / 64'(NUM_COLUMNS));
  localparam logic [RECIP_W-1:0] RECIP_MELT = RECIP_W'(
    ((64'd1 << SHIFT_MELT) + 64'(MELT_HEIGHT) - 64'd1) / 64'(MELT_HEIGHT));

  cmw_pkg::state_t state, state_next;

  cmw_pkg::in_item_t item, item_next;
  logic [ADDR_W-1:0] seed_pos, seed_pos_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [ADDR_W-1:0] pipe_idx, pipe_idx_next;
  logic pipe_valid, pipe_valid_next;
  logic tick_done, tick_done_next;
  logic [5:0] ticks_left, ticks_left_next;
  logic [1:0] phase, phase_next;
  logic [MAG_W-1:0] query_mag, query_mag_next;
  logic [PROD_W-1:0] prod, prod_next;
  logic [cmw_pkg::FIELD_W-1:0] left_q, left_q_next;
  logic [cmw_pkg::FIELD_W-1:0] right_q, right_q_next;
  cmw_pkg::out_item_t result_next;
  logic result_valid_next;

  logic [cmw_pkg::FIELD_W-1:0] screen_width;
  logic [cmw_pkg::FIELD_W-1:0] screen_height;

  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [OFF_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [OFF_W-1:0] ram_rdata;

  logic signed [OFF_W:0] off_x;
  logic signed [OFF_W:0] grow_sum;
  logic signed [OFF_W:0] grow_new;
  logic off_changed;
  logic signed [OFF_W:0] seed_step;
  logic signed [OFF_W:0] seed_sum;
  logic signed [OFF_W:0] seed_new;
  logic [OFF_W-1:0] seed_first;
  logic [3:0] seed_bits;
  logic [ADDR_W-1:0] seed_pos_inc;

  logic [MUL_A_W-1:0] mul_a;
  logic [cmw_pkg::FIELD_W-1:0] mul_b;
  logic [RECIP_W-1:0] mul_x;
  logic [RECIP_W-1:0] mul_y;
  logic [MUL_W-1:0] mul_prod;
  logic [cmw_pkg::FIELD_W-1:0] div_field;

  cmw_ram #(
    .WIDTH (OFF_W),
    .DEPTH (NUM_COLUMNS)
  ) u_offsets (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state != cmw_pkg::ST_IDLE);

  // Melt step and seed step on the offset read back from the RAM.
  always_comb begin
    off_x = (OFF_W + 1)'($signed(ram_rdata));
    off_changed = (off_x < MELT_X);
    if (off_x < ZERO_X) begin
      grow_sum = off_x + ONE_X;
    end else if (off_x < GROW_LIMIT_X) begin
      grow_sum = off_x + off_x + ONE_X;
    end else begin
      grow_sum = off_x + GROW_STEP_X;
    end
    grow_new = (grow_sum > MELT_X) ? MELT_X : grow_sum;

    seed_step = (OFF_W + 1)'(cmw_pkg::mod3(item.random_value)) - ONE_X;
    seed_sum = off_x + seed_step;
    if (seed_sum < SEED_MIN_X) begin
      seed_new = SEED_MIN_X;
    end else if (seed_sum > ZERO_X) begin
      seed_new = ZERO_X;
    end else begin
      seed_new = seed_sum;
    end

    seed_bits = 4'(command.random_value & 8'(cmw_pkg::SEED_MASK));
    seed_first = OFF_W'(-$signed({1'b0, seed_bits}));
    seed_pos_inc = (seed_pos == LAST_COL) ? '0 : seed_pos + 1'b1;
  end

  // Shared multiplier: the scaled product first, then the reciprocal of the
  // constant divisor, whose high bits give the truncated quotient.
  always_comb begin
    case (phase)
      cmw_pkg::PHASE_LEFT: mul_a = MUL_A_W'(item.column);
      cmw_pkg::PHASE_RIGHT: mul_a = MUL_A_W'({1'b0, item.column} + 10'd1);
      default: mul_a = MUL_A_W'(query_mag);
    endcase
    mul_b = (phase == cmw_pkg::PHASE_TOP) ? screen_height : screen_width;

    if (state == cmw_pkg::ST_Q_DIV) begin
      mul_x = RECIP_W'(prod);
      mul_y = (phase == cmw_pkg::PHASE_TOP) ? RECIP_MELT : RECIP_COL;
    end else begin
      mul_x = RECIP_W'(mul_a);
      mul_y = RECIP_W'(mul_b);
    end
    mul_prod = MUL_W'(mul_x) * MUL_W'(mul_y);

    if (phase == cmw_pkg::PHASE_TOP) begin
      div_field = mul_prod[SHIFT_MELT +: cmw_pkg::FIELD_W];
    end else begin
      div_field = mul_prod[SHIFT_COL +: cmw_pkg::FIELD_W];
    end
  end

  always_comb begin
    state_next = state;
    item_next = item;
    seed_pos_next = seed_pos;
    idx_next = idx;
    pipe_idx_next = pipe_idx;
    pipe_valid_next = pipe_valid;
    tick_done_next = tick_done;
    ticks_left_next = ticks_left;
    phase_next = phase;
    query_mag_next = query_mag;
    prod_next = prod;
    left_q_next = left_q;
    right_q_next = right_q;
    result_next = '0;
    result_valid_next = 1'b0;
    ram_we = 1'b0;
    ram_waddr = pipe_idx;
    ram_wdata = grow_new[OFF_W-1:0];
    ram_raddr = idx;

    case (state)
      cmw_pkg::ST_IDLE: begin
        if (command.action == cmw_pkg::ACT_SEED) begin
          ram_raddr = seed_pos - 1'b1;
        end else begin
          ram_raddr = ADDR_W'(command.column);
        end
        if (start) begin
          item_next = command;
          case (command.action)
            cmw_pkg::ACT_SEED: begin
              if (seed_pos == '0) begin
                ram_we = 1'b1;
                ram_waddr = '0;
                ram_wdata = seed_first;
                seed_pos_next = seed_pos_inc;
                result_valid_next = 1'b1;
              end else begin
                state_next = cmw_pkg::ST_SEED;
              end
            end
            cmw_pkg::ACT_ADVANCE: begin
              if (command.tick_count == '0) begin
                result_valid_next = 1'b1;
              end else begin
                ticks_left_next = command.tick_count;
                idx_next = '0;
                pipe_valid_next = 1'b0;
                tick_done_next = 1'b1;
                state_next = cmw_pkg::ST_ADV;
              end
            end
            cmw_pkg::ACT_QUERY: begin
              state_next = cmw_pkg::ST_Q_LOAD;
            end
            default: begin
              result_valid_next = 1'b1;
            end
          endcase
        end
      end

      cmw_pkg::ST_SEED: begin
        ram_we = 1'b1;
        ram_waddr = seed_pos;
        ram_wdata = seed_new[OFF_W-1:0];
        seed_pos_next = seed_pos_inc;
        result_valid_next = 1'b1;
        state_next = cmw_pkg::ST_IDLE;
      end

      cmw_pkg::ST_ADV: begin
        ram_raddr = idx;
        pipe_valid_next = 1'b1;
        pipe_idx_next = idx;
        if (pipe_valid && off_changed) begin
          ram_we = 1'b1;
          tick_done_next = 1'b0;
        end
        if (idx == LAST_COL) begin
          state_next = cmw_pkg::ST_ADV_TAIL;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      cmw_pkg::ST_ADV_TAIL: begin
        pipe_valid_next = 1'b0;
        ram_we = off_changed;
        if (ticks_left == 6'd1) begin
          result_next.done_res = tick_done && !off_changed;
          result_valid_next = 1'b1;
          state_next = cmw_pkg::ST_IDLE;
        end else begin
          ticks_left_next = ticks_left - 1'b1;
          idx_next = '0;
          tick_done_next = 1'b1;
          state_next = cmw_pkg::ST_ADV;
        end
      end

      cmw_pkg::ST_Q_LOAD: begin
        if ({2'b00, item.column} >= COL_LIMIT) begin
          result_valid_next = 1'b1;
          state_next = cmw_pkg::ST_IDLE;
        end else begin
          query_mag_next = (off_x > ZERO_X) ? ram_rdata[MAG_W-1:0] : '0;
          phase_next = cmw_pkg::PHASE_LEFT;
          state_next = cmw_pkg::ST_Q_MUL;
        end
      end

      cmw_pkg::ST_Q_MUL: begin
        prod_next = PROD_W'(mul_prod);
        state_next = cmw_pkg::ST_Q_DIV;
      end

      cmw_pkg::ST_Q_DIV: begin
        case (phase)
          cmw_pkg::PHASE_LEFT: begin
            left_q_next = div_field;
            phase_next = cmw_pkg::PHASE_RIGHT;
            state_next = cmw_pkg::ST_Q_MUL;
          end
          cmw_pkg::PHASE_RIGHT: begin
            right_q_next = div_field;
            phase_next = cmw_pkg::PHASE_TOP;
            state_next = cmw_pkg::ST_Q_MUL;
          end
          default: begin
            result_next.left_x = left_q;
            result_next.right_x = right_q;
            result_next.strip_top = div_field;
            result_next.visible = (div_field < screen_height);
            result_valid_next = 1'b1;
            state_next = cmw_pkg::ST_IDLE;
          end
        endcase
      end

      default: begin
        state_next = cmw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmw_pkg::ST_IDLE;
      seed_pos <= '0;
      idx <= '0;
      pipe_idx <= '0;
      pipe_valid <= 1'b0;
      tick_done <= 1'b0;
      ticks_left <= '0;
      phase <= cmw_pkg::PHASE_LEFT;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      seed_pos <= seed_pos_next;
      idx <= idx_next;
      pipe_idx <= pipe_idx_next;
      pipe_valid <= pipe_valid_next;
      tick_done <= tick_done_next;
      ticks_left <= ticks_left_next;
      phase <= phase_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    query_mag <= query_mag_next;
    prod <= prod_next;
    left_q <= left_q_next;
    right_q <= right_q_next;
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= cmw_pkg::SCREEN_WIDTH_RESET;
      screen_height <= cmw_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cmw_pkg::REG_SCREEN_WIDTH: screen_width <= cfg_data;
        cmw_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cmw_ram.sv -----
// ----------------------------------------------------------------------------
// Column melt wipe RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cmw_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 320
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- bench/tb_column_melt_wipe.sv -----
// ----------------------------------------------------------------------------
// Column melt wipe testbench
// Drives seed, advance and query transactions into the column melt wipe
// block, with random idle gaps, across several screen sizes. The bench keeps
// its own model of the drop offsets and compares every result, field by field,
// with the expected one. A directed table comes first, then random traffic.
// ----------------------------------------------------------------------------
module tb_column_melt_wipe;
  timeunit 1ns;
  timeprecision 1ps;

  import cmw_pkg::*;

  localparam int COLS = 320;
  localparam int MELT_H = 200;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    in_item_t  cmd;
    bit        fixed;
    out_item_t want;
  } melt_row_t;

  typedef struct {
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] height;
  } screen_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  in_item_t               command = '0;
  logic                   result_valid;
  out_item_t              result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0]     cfg_data = '0;

  logic signed [8:0]  col_drop [COLS];
  logic [8:0]         next_seed_col;
  int                 seeds_done;
  logic [FIELD_W-1:0] cur_width;
  logic [FIELD_W-1:0] cur_height;
  out_item_t          strips_due [$];
  int                 mismatches = 0;
  int                 cycles = 0;
  bit                 gaps_on = 1'b1;

  column_melt_wipe u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  melt_row_t directed_rows [21] = '{
    '{'{ACT_QUERY,   8'h00, 6'h00, 9'd320}, 1'b1, '0},
    '{'{ACT_QUERY,   8'hFF, 6'h3F, 9'd511}, 1'b1, '0},
    '{'{ACT_UNUSED,  8'hFF, 6'h3F, 9'd511}, 1'b1, '0},
    '{'{ACT_SEED,    8'h0F, 6'h3F, 9'd511}, 1'b1, '0},
    '{'{ACT_SEED,    8'hFF, 6'h00, 9'd0},   1'b1, '0},
    '{'{ACT_SEED,    8'h00, 6'h00, 9'd0},   1'b1, '0},
    '{'{ACT_SEED,    8'h02, 6'h00, 9'd0},   1'b1, '0},
    '{'{ACT_ADVANCE, 8'hFF, 6'h00, 9'd511}, 1'b1, '0},
    '{'{ACT_QUERY,   8'h00, 6'h00, 9'd0},   1'b1, '{1'b0, 13'd0, 13'd1, 13'd0, 1'b1}},
    '{'{ACT_QUERY,   8'h00, 6'h00, 9'd319}, 1'b0, '0},
    '{'{ACT_ADVANCE, 8'h00, 6'd1,  9'd0},   1'b0, '0},
    '{'{ACT_ADVANCE, 8'h00, 6'h3F, 9'd0},   1'b0, '0},
    '{'{ACT_QUERY,   8'h00, 6'h00, 9'd0},   1'b0, '0},
    '{'{ACT_QUERY,   8'h00, 6'h00, 9'd319}, 1'b0, '0},
    '{'{ACT_QUERY,   8'h00, 6'h00, 9'd160}, 1'b0, '0},
    '{'{ACT_SEED,    8'h55, 6'h2A, 9'h155}, 1'b1, '0},
    '{'{ACT_SEED,    8'hAA, 6'h15, 9'h0AA}, 1'b1, '0},
    '{'{ACT_ADVANCE, 8'h00, 6'd2,  9'd0},   1'b0, '0},
    '{'{ACT_QUERY,   8'h00, 6'h00, 9'd1},   1'b0, '0},
    '{'{ACT_QUERY,   8'h00, 6'h00, 9'h155}, 1'b1, '0},
    '{'{ACT_ADVANCE, 8'hFF, 6'h00, 9'd5},   1'b1, '0}
  };

  screen_t screen_modes [PHASES] = '{
    '{13'd320,  13'd200},
    '{13'd0,    13'd0},
    '{13'd1,    13'd1},
    '{13'd4096, 13'd4096},
    '{13'd8191, 13'd8191},
    '{13'd0,    13'd0},
    '{13'd640,  13'd400}
  };

  function automatic out_item_t melt_predict(in_item_t c);
    out_item_t r;
    int v;
    int nv;
    int left;
    int right;
    int top;
    r = '0;
    case (c.action)
      ACT_SEED: begin
        if (next_seed_col == 0) begin
          col_drop[0] = 9'(-int'(c.random_value[3:0]));
        end else begin
          v = int'(col_drop[next_seed_col - 1]) + int'(c.random_value % 8'd3) - 1;
          if (v < -15) v = -15;
          if (v > 0) v = 0;
          col_drop[next_seed_col] = 9'(v);
        end
        next_seed_col = (next_seed_col == COLS - 1) ? '0 : next_seed_col + 1'b1;
        if (seeds_done < COLS) seeds_done++;
      end
      ACT_ADVANCE: begin
        for (int t = 0; t < int'(c.tick_count); t++) begin
          r.done_res = 1'b1;
          for (int i = 0; i < COLS; i++) begin
            v = int'(col_drop[i]);
            if (v < 0) begin
              col_drop[i] = 9'(v + 1);
              r.done_res = 1'b0;
            end else if (v < MELT_H) begin
              nv = (v < 16) ? 2 * v + 1 : v + 8;
              if (nv > MELT_H) nv = MELT_H;
              col_drop[i] = 9'(nv);
              r.done_res = 1'b0;
            end
          end
        end
      end
      ACT_QUERY: begin
        if (int'(c.column) < COLS) begin
          left = int'(c.column) * int'(cur_width) / COLS;
          right = (int'(c.column) + 1) * int'(cur_width) / COLS;
          v = int'(col_drop[c.column]);
          top = (v > 0) ? v * int'(cur_height) / MELT_H : 0;
          r.left_x = FIELD_W'(left);
          r.right_x = FIELD_W'(right);
          r.strip_top = FIELD_W'(top);
          r.visible = (r.strip_top < cur_height);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t c;
    int pick;
    int span;
    c.random_value = 8'($urandom);
    c.tick_count = 6'($urandom);
    c.column = 9'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      c.action = ACT_SEED;
    end else if (pick < 56) begin
      c.action = ACT_ADVANCE;
      span = $urandom_range(0, 99);
      if (span < 85) c.tick_count = 6'($urandom_range(0, 3));
      else if (span < 97) c.tick_count = 6'($urandom_range(4, 16));
      else c.tick_count = 6'($urandom_range(17, 63));
    end else if (pick < 95) begin
      c.action = ACT_QUERY;
      if (pick < 92) c.column = 9'($urandom_range(0, COLS - 1));
      else c.column = 9'($urandom_range(COLS, 511));
    end else begin
      c.action = ACT_UNUSED;
    end
    return c;
  endfunction

  task automatic issue(in_item_t c, bit fixed, out_item_t want);
    out_item_t predicted;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start <= 1'b1;
    command <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = melt_predict(c);
    strips_due.push_back(fixed ? want : predicted);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (strips_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic program_screen(logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= REG_SPARE_A;
    cfg_data <= FIELD_W'($urandom);
    @(posedge clk);
    cfg_index <= REG_SPARE_B;
    cfg_data <= FIELD_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_width = w;
    cur_height = h;
  endtask

  always @(posedge clk) begin
    out_item_t due;
    if (!rst && result_valid) begin
      if (strips_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: done=%0d left=%0d right=%0d top=%0d vis=%0d",
                   result.done_res, result.left_x, result.right_x, result.strip_top,
                   result.visible);
      end else begin
        due = strips_due.pop_front();
        if (result.done_res !== due.done_res || result.left_x !== due.left_x ||
            result.right_x !== due.right_x || result.strip_top !== due.strip_top ||
            result.visible !== due.visible) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp done=%0d left=%0d right=%0d top=%0d vis=%0d, %s",
                     $realtime, due.done_res, due.left_x, due.right_x, due.strip_top,
                     due.visible,
                     $sformatf("got done=%0d left=%0d right=%0d top=%0d vis=%0d",
                               result.done_res, result.left_x, result.right_x,
                               result.strip_top, result.visible));
        end
      end
    end
  end

  initial begin
    in_item_t fill;
    cur_width = SCREEN_WIDTH_RESET;
    cur_height = SCREEN_HEIGHT_RESET;
    next_seed_col = '0;
    seeds_done = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Columns must all be seeded before any advance or in-range query reads them.
    foreach (directed_rows[n]) begin
      if ((directed_rows[n].cmd.action == ACT_ADVANCE ||
           (directed_rows[n].cmd.action == ACT_QUERY &&
            int'(directed_rows[n].cmd.column) < COLS)) && seeds_done < COLS) begin
        while (seeds_done < COLS) begin
          fill = random_item();
          fill.action = ACT_SEED;
          issue(fill, 1'b1, '0);
        end
      end
      issue(directed_rows[n].cmd, directed_rows[n].fixed, directed_rows[n].want);
    end
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 5)
        program_screen(FIELD_W'($urandom_range(1, 4096)), FIELD_W'($urandom_range(1, 4096)));
      else if (p > 0)
        program_screen(screen_modes[p].width, screen_modes[p].height);
      gaps_on = (p != PHASES - 1);
      repeat (ITEMS_PER_PHASE) issue(random_item(), 1'b0, '0);
      settle();
    end

    if (mismatches == 0 && strips_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- column_melt_wipe.f -----
rtl/cmw_pkg.sv
rtl/cmw_ram.sv
rtl/column_melt_wipe.sv
bench/tb_column_melt_wipe.sv
